[rtl/papc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the persistent array (path-copy segment tree).
// No dependencies; imported by the front, queue, back and top modules.
package papc_pkg;

    // field widths
    localparam int LC_W    = 11;   // leaf_count and position
    localparam int BV_W    = 10;   // base_version and created_version
    localparam int VAL_W   = 32;   // leaf values
    localparam int ST_W    = 3;    // status
    localparam int RT_W    = 2;    // req_type
    localparam int NEED_W  = 4;    // tree levels on one path, at most 11

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // request kinds
    localparam logic [RT_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [RT_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [RT_W-1:0] REQ_QUERY  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_POOL_FULL = 3'd1;
    localparam logic [ST_W-1:0] ST_VER_FULL  = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_VER   = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd4;

    // classified request, as handed from front to back
    typedef struct packed {
        logic [RT_W-1:0]   req_type;
        logic [BV_W-1:0]   base_version;
        logic [LC_W-1:0]   position;
        logic [VAL_W-1:0]  new_value;
        logic              pos_ok;
        logic [NEED_W-1:0] need;       // nodes an update copies
    } t_entry;

    // one result
    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [BV_W-1:0]  created_version;
        logic [ST_W-1:0]  status;
    } t_result;

endpackage

[rtl/papc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts request transactions, checks the position and counts
// the tree levels an update will copy. Depends on papc_pkg.
module papc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_req_type,
    input  logic [9:0]            i_base_version,
    input  logic [10:0]           i_position,
    input  logic [31:0]           i_new_value,
    input  logic [10:0]           i_leaf_count,
    output logic                  o_push,
    output papc_pkg::t_entry      o_entry,
    input  logic                  i_full
);
    import papc_pkg::*;

    logic              r_busy;
    t_entry            r_entry;
    logic [LC_W-1:0]   r_lo;
    logic [LC_W-1:0]   r_hi;
    logic [LC_W:0]     sum;
    logic [LC_W-1:0]   mid;
    logic              pos_ok_in;
    logic              walking;
    logic              done;

    // position range check on the incoming transaction
    assign pos_ok_in = (i_position != '0) && (i_position <= i_leaf_count);

    // halving step over [lo, hi]
    assign sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = sum[LC_W:1];
    assign walking = (r_entry.req_type == REQ_UPDATE) && r_entry.pos_ok;
    assign done    = !walking || (r_lo == r_hi);

    assign o_ready = !r_busy;
    assign o_push  = r_busy && done && !i_full;
    assign o_entry = r_entry;

    // one level per cycle until the leaf range is reached
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_busy                <= 1'b1;
                r_entry.req_type      <= i_req_type;
                r_entry.base_version  <= i_base_version;
                r_entry.position      <= i_position;
                r_entry.new_value     <= i_new_value;
                r_entry.pos_ok        <= pos_ok_in;
                r_entry.need          <= NEED_W'(1);
                r_lo                  <= LC_W'(1);
                r_hi                  <= i_leaf_count;
            end else if (r_busy) begin
                if (o_push) begin
                    r_busy <= 1'b0;
                end else if (!done) begin
                    if (r_entry.position <= mid) begin
                        r_hi <= mid;
                    end else begin
                        r_lo <= mid + LC_W'(1);
                    end
                    r_entry.need <= r_entry.need + NEED_W'(1);
                end
            end
        end
    end

endmodule

[rtl/papc_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of classified requests between front and back end.
// Depends on papc_pkg.
module papc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  papc_pkg::t_entry      i_entry,
    output logic                  o_full,
    input  logic                  i_pop,
    output papc_pkg::t_entry      o_head,
    output logic                  o_empty
);
    import papc_pkg::*;

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop && !o_empty) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("front pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("back popped an empty queue");

endmodule

[rtl/papc_back.sv]
`timescale 1ns / 1ps
// Back end: version table, node pool and base leaves; walks and copies the
// root-to-leaf path, holds leaf_count and the result register. Depends on papc_pkg.
module papc_back #(
    parameter int MAX_LEAVES   = 1024,
    parameter int POOL_NODES   = 65536,
    parameter int MAX_VERSIONS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [10:0]           i_cfg_data,
    output logic [10:0]           o_leaf_count,
    input  logic                  i_empty,
    input  papc_pkg::t_entry      i_head,
    output logic                  o_pop,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output papc_pkg::t_result     o_result
);
    import papc_pkg::*;

    localparam int PW = $clog2(POOL_NODES);
    localparam int VW = $clog2(MAX_VERSIONS);
    localparam int LW = $clog2(MAX_LEAVES);

    // node reference: top bit marks the implicit base tree
    typedef logic [PW:0] t_ref;
    typedef struct packed {
        t_ref             left;
        t_ref             right;
        logic [VAL_W-1:0] value;
    } t_node;

    localparam t_ref BASE_REF = {1'b1, {PW{1'b0}}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROOT  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // memories
    t_node             r_pool_mem  [POOL_NODES];
    logic [VAL_W-1:0]  r_base_mem  [MAX_LEAVES];
    t_ref              r_roots_mem [MAX_VERSIONS];
    t_node             r_pool_rd;
    logic [VAL_W-1:0]  r_base_rd;
    t_ref              r_roots_rd;

    // control and datapath registers
    logic [2:0]        r_state;
    logic [LC_W-1:0]   r_leaf_count;
    logic [VW:0]       r_vcount;
    logic [PW:0]       r_next_free;
    t_entry            r_item;
    t_ref              r_cur;
    t_ref              r_root;
    logic [LC_W-1:0]   r_lo;
    logic [LC_W-1:0]   r_hi;
    logic [PW:0]       r_dst;
    t_result           r_res;
    t_result           r_out;
    logic              r_out_valid;

    // combinational helpers
    logic [LC_W-1:0]   lc_sat;
    logic [31:0]       bv_ext;
    logic [31:0]       wpos_ext;
    logic [31:0]       rlo_ext;
    logic              bv_bad;
    logic              vt_full;
    logic              pool_full;
    logic [ST_W-1:0]   idle_status;
    logic              idle_go;
    logic [LC_W:0]     sum;
    logic [LC_W-1:0]   mid;
    logic              go_right;
    logic              at_leaf;
    logic              is_update;
    t_node             node;
    logic [VAL_W-1:0]  leaf_val;
    logic [PW:0]       dst_next;
    logic              pool_we;
    t_node             pool_wdata;
    logic              base_we;
    logic              roots_we;
    t_ref              roots_wdata;
    logic              out_free;

    assign o_cfg_ready  = 1'b1;
    assign o_leaf_count = r_leaf_count;
    assign o_m_valid    = r_out_valid;
    assign o_result     = r_out;
    assign out_free     = !r_out_valid || i_m_ready;

    // leaf_count write is clamped to 1..MAX_LEAVES
    always_comb begin
        lc_sat = i_cfg_data;
        if (i_cfg_data == '0) begin
            lc_sat = LC_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_LEAVES)) begin
            lc_sat = 11'(MAX_LEAVES);
        end
    end

    // classify the queue head: error order is version, position, table, pool
    assign bv_ext    = 32'(i_head.base_version);
    assign wpos_ext  = 32'(i_head.position) - 32'd1;
    assign bv_bad    = bv_ext >= 32'(r_vcount);
    assign vt_full   = 32'(r_vcount) == 32'(MAX_VERSIONS);
    assign pool_full = (32'(r_next_free) + 32'(i_head.need)) > 32'(POOL_NODES);

    always_comb begin
        idle_status = ST_OK;
        idle_go     = 1'b0;
        unique case (i_head.req_type) inside
            REQ_LOAD: begin
                if (!i_head.pos_ok) idle_status = ST_BAD_POS;
            end
            REQ_UPDATE, REQ_QUERY: begin
                if (bv_bad) begin
                    idle_status = ST_BAD_VER;
                end else if (!i_head.pos_ok) begin
                    idle_status = ST_BAD_POS;
                end else if (vt_full) begin
                    idle_status = ST_VER_FULL;
                end else if ((i_head.req_type == REQ_UPDATE) && pool_full) begin
                    idle_status = ST_POOL_FULL;
                end else begin
                    idle_go = 1'b1;
                end
            end
            default: idle_status = ST_OK;
        endcase
    end

    // current level of the walk
    assign sum       = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = sum[LC_W:1];
    assign go_right  = r_item.position > mid;
    assign at_leaf   = (r_lo == r_hi);
    assign is_update = (r_item.req_type == REQ_UPDATE);
    assign rlo_ext   = 32'(r_lo) - 32'd1;
    assign dst_next  = r_dst + (PW+1)'(1);

    // base nodes have base children; pool nodes come from memory
    always_comb begin
        if (r_cur[PW]) begin
            node.left  = BASE_REF;
            node.right = BASE_REF;
            node.value = r_base_rd;
        end else begin
            node = r_pool_rd;
        end
    end
    assign leaf_val = r_cur[PW] ? r_base_rd : r_pool_rd.value;

    // memory write controls
    always_comb begin
        pool_we     = 1'b0;
        pool_wdata  = node;
        base_we     = 1'b0;
        roots_we    = 1'b0;
        roots_wdata = is_update ? {1'b0, r_next_free[PW-1:0]} : r_root;
        unique case (r_state)
            S_IDLE: begin
                base_we = !i_empty && (i_head.req_type == REQ_LOAD) && i_head.pos_ok;
            end
            S_STEP: begin
                pool_we = is_update;
                if (at_leaf) begin
                    pool_wdata.value = r_item.new_value;
                    roots_we         = 1'b1;
                end else if (go_right) begin
                    pool_wdata.right = {1'b0, dst_next[PW-1:0]};
                end else begin
                    pool_wdata.left  = {1'b0, dst_next[PW-1:0]};
                end
            end
            default: begin
                pool_we = 1'b0;
            end
        endcase
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // node pool
    always_ff @(posedge i_clk) begin
        if (pool_we) begin
            r_pool_mem[r_dst[PW-1:0]] <= pool_wdata;
        end
        r_pool_rd <= r_pool_mem[r_cur[PW-1:0]];
    end

    // base leaves, addressed by position minus one
    always_ff @(posedge i_clk) begin
        if (base_we) begin
            r_base_mem[wpos_ext[LW-1:0]] <= i_head.new_value;
        end
        r_base_rd <= r_base_mem[rlo_ext[LW-1:0]];
    end

    // version roots; entry zero is the base root and never stored
    always_ff @(posedge i_clk) begin
        if (roots_we) begin
            r_roots_mem[r_vcount[VW-1:0]] <= roots_wdata;
        end
        r_roots_rd <= r_roots_mem[bv_ext[VW-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_leaf_count <= LC_W'(1);
            r_vcount     <= (VW+1)'(1);
            r_next_free  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_leaf_count <= lc_sat;
                r_vcount     <= (VW+1)'(1);
                r_next_free  <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_item <= i_head;
                        if (idle_go) begin
                            r_state <= S_ROOT;
                        end else begin
                            r_res.read_value      <= '0;
                            r_res.created_version <= '0;
                            r_res.status          <= idle_status;
                            r_state               <= S_DONE;
                        end
                    end
                end
                S_ROOT: begin
                    if (r_item.base_version == '0) begin
                        r_cur  <= BASE_REF;
                        r_root <= BASE_REF;
                    end else begin
                        r_cur  <= r_roots_rd;
                        r_root <= r_roots_rd;
                    end
                    r_lo    <= LC_W'(1);
                    r_hi    <= r_leaf_count;
                    r_dst   <= r_next_free;
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (at_leaf) begin
                        r_res.read_value      <= is_update ? '0 : leaf_val;
                        r_res.created_version <= r_vcount[BV_W-1:0];
                        r_res.status          <= ST_OK;
                        r_vcount              <= r_vcount + (VW+1)'(1);
                        if (is_update) begin
                            r_next_free <= dst_next;
                        end
                        r_state <= S_DONE;
                    end else begin
                        if (go_right) begin
                            r_cur <= node.right;
                            r_lo  <= mid + LC_W'(1);
                        end else begin
                            r_cur <= node.left;
                            r_hi  <= mid;
                        end
                        if (is_update) begin
                            r_dst <= dst_next;
                        end
                        r_state <= S_FETCH;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_vcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vcount != '0) && (32'(r_vcount) <= 32'(MAX_VERSIONS)))
        else $error("version count out of range");

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_next_free) <= 32'(POOL_NODES))
        else $error("pool allocation beyond pool size");

    a_copy_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) && is_update |-> 32'(r_dst) < 32'(POOL_NODES))
        else $error("path copy writes past the pool");

    a_fetch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_state == S_STEP))
        else $error("node read not followed by its step");

endmodule

[rtl/persistent_array_path_copy_top.sv]
`timescale 1ns / 1ps
// Top level of the versioned array: front end, request queue and back end.
// Depends on papc_pkg, papc_front, papc_queue, papc_back.
//
//  channel     | direction | handshake                     | payload
//  ------------+-----------+-------------------------------+------------------------------
//  s_axis      | in        | s_axis_tvalid / s_axis_tready | tuser req_type, tdata request
//  m_axis      | out       | m_axis_tvalid / m_axis_tready | tuser status, tdata result
//  cfg         | in        | i_cfg_valid / o_cfg_ready     | i_cfg_data leaf_count
//
// In the back end an update or query walks the L tree levels on its path (11 at
// 1024 leaves): each level is a memory read in S_FETCH followed by S_STEP, which
// for an update writes the copied node. Loads and rejected requests go from S_IDLE
// straight to S_DONE. The front end counts an update's path at one level per cycle
// while the back end works on earlier requests. Reset is synchronous and needs
// no clearing pass; a full queue or a held result stalls the side before it.
module persistent_array_path_copy_top #(
    parameter int MAX_LEAVES   = 1024,
    parameter int POOL_NODES   = 65536,
    parameter int MAX_VERSIONS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // base_version[9:0], position[20:10], new_value[52:21]
    input  logic [1:0]   s_axis_tuser,   // req_type[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // read_value[31:0], created_version[41:32]
    output logic [2:0]   m_axis_tuser,   // status[2:0]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [10:0]  i_cfg_data
);
    import papc_pkg::*;

    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_entry      entry;
    t_entry      head;
    t_result     result;
    logic [10:0] leaf_count;

    papc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_req_type     (s_axis_tuser),
        .i_base_version (s_axis_tdata[9:0]),
        .i_position     (s_axis_tdata[20:10]),
        .i_new_value    (s_axis_tdata[52:21]),
        .i_leaf_count   (leaf_count),
        .o_push         (push),
        .o_entry        (entry),
        .i_full         (full)
    );

    papc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    papc_back #(
        .MAX_LEAVES   (MAX_LEAVES),
        .POOL_NODES   (POOL_NODES),
        .MAX_VERSIONS (MAX_VERSIONS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_leaf_count (leaf_count),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_result     (result)
    );

    // result packing, padded to whole bytes
    assign m_axis_tdata = {6'd0, result.created_version, result.read_value};
    assign m_axis_tuser = result.status;

endmodule

[tb/persistent_array_path_copy_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for persistent_array_path_copy_top: watches the request, result and
// leaf_count channels, keeps its own versioned tree and compares every result.
// Depends on papc_pkg.
module persistent_array_path_copy_checker
    import papc_pkg::*;
#(
    parameter int MAX_LEAVES   = 1024,
    parameter int POOL_NODES   = 65536,
    parameter int MAX_VERSIONS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [55:0] i_req_data,    // base_version[9:0], position[20:10], new_value[52:21]
    input  logic [1:0]  i_req_user,    // req_type[1:0]
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [47:0] i_res_data,    // read_value[31:0], created_version[41:32]
    input  logic [2:0]  i_res_user,    // status[2:0]
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [10:0] i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);

    // node references at or above POOL_NODES name base node (ref - POOL_NODES)
    logic [VAL_W-1:0] base_leaf [0:MAX_LEAVES];
    int unsigned      node_left [POOL_NODES];
    int unsigned      node_right [POOL_NODES];
    logic [VAL_W-1:0] node_val [POOL_NODES];
    int unsigned      ver_root [MAX_VERSIONS];
    int unsigned      free_idx;
    int unsigned      ver_total;
    int unsigned      leaves;
    t_result          results_due [$];
    int               errors;

    assign o_fail_count = errors;

    initial begin
        errors = 0;
        for (int i = 0; i <= MAX_LEAVES; i++) base_leaf[i] = '0;
    end

    task automatic report(input string msg);
        errors++;
        if (errors <= 40) $display("%0t ns: %s", $time, msg);
    endtask

    // keep only the base tree
    function automatic void drop_versions();
        ver_root[0] = POOL_NODES + 1;
        free_idx    = 0;
        ver_total   = 1;
    endfunction

    function automatic int unsigned child_ref(input int unsigned r, input bit right);
        if (r >= POOL_NODES) return POOL_NODES + 2 * (r - POOL_NODES) + right;
        return right ? node_right[r] : node_left[r];
    endfunction

    function automatic logic [VAL_W-1:0] leaf_at(input int unsigned r, input int unsigned pos);
        int unsigned lo, hi, mid;
        lo = 1;
        hi = leaves;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (pos <= mid) begin
                r  = child_ref(r, 1'b0);
                hi = mid;
            end else begin
                r  = child_ref(r, 1'b1);
                lo = mid + 1;
            end
        end
        if (r >= POOL_NODES) return base_leaf[lo];
        return node_val[r];
    endfunction

    function automatic int unsigned path_levels(input int unsigned pos);
        int unsigned lo, hi, mid, n;
        lo = 1;
        hi = leaves;
        n  = 1;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (pos <= mid) hi = mid;
            else lo = mid + 1;
            n++;
        end
        return n;
    endfunction

    // copy the root-to-leaf path into the pool, returns the new root
    function automatic int unsigned copy_path(input int unsigned src, input int unsigned pos,
                                              input logic [VAL_W-1:0] val);
        int unsigned lo, hi, mid, dst, root, parent;
        bit          have_parent, side, done;
        lo          = 1;
        hi          = leaves;
        root        = 0;
        parent      = 0;
        have_parent = 1'b0;
        side        = 1'b0;
        done        = 1'b0;
        while (!done) begin
            dst = free_idx;
            free_idx++;
            if (src >= POOL_NODES) begin
                node_left[dst]  = child_ref(src, 1'b0);
                node_right[dst] = child_ref(src, 1'b1);
                node_val[dst]   = (lo == hi) ? base_leaf[lo] : '0;
            end else begin
                node_left[dst]  = node_left[src];
                node_right[dst] = node_right[src];
                node_val[dst]   = node_val[src];
            end
            if (have_parent) begin
                if (side) node_right[parent] = dst;
                else node_left[parent] = dst;
            end else begin
                root = dst;
            end
            if (lo == hi) begin
                node_val[dst] = val;
                done = 1'b1;
            end else begin
                mid = (lo + hi) >> 1;
                if (pos <= mid) begin
                    src  = node_left[dst];
                    hi   = mid;
                    side = 1'b0;
                end else begin
                    src  = node_right[dst];
                    lo   = mid + 1;
                    side = 1'b1;
                end
                parent      = dst;
                have_parent = 1'b1;
            end
        end
        return root;
    endfunction

    function automatic t_result apply_request(input logic [RT_W-1:0] rt,
                                              input logic [BV_W-1:0] bv,
                                              input logic [LC_W-1:0] pos,
                                              input logic [VAL_W-1:0] val);
        t_result res;
        bit      pos_ok;
        res    = '0;
        pos_ok = (pos >= 1) && (pos <= leaves);
        case (rt)
            REQ_LOAD: begin
                if (!pos_ok) res.status = ST_BAD_POS;
                else base_leaf[pos] = val;
            end
            REQ_UPDATE, REQ_QUERY: begin
                if (bv >= ver_total) res.status = ST_BAD_VER;
                else if (!pos_ok) res.status = ST_BAD_POS;
                else if (ver_total >= MAX_VERSIONS) res.status = ST_VER_FULL;
                else if (rt == REQ_UPDATE && free_idx + path_levels(pos) > POOL_NODES)
                    res.status = ST_POOL_FULL;
                else begin
                    if (rt == REQ_UPDATE) begin
                        ver_root[ver_total] = copy_path(ver_root[bv], pos, val);
                    end else begin
                        res.read_value      = leaf_at(ver_root[bv], pos);
                        ver_root[ver_total] = ver_root[bv];
                    end
                    res.created_version = ver_total[BV_W-1:0];
                    ver_total++;
                end
            end
            default: ;  // unknown request: no change, all fields zero
        endcase
        return res;
    endfunction

    // results first, so a result can only match requests from earlier edges
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        int unsigned lc;
        if (!i_rst_n) begin
            leaves = 1;
            drop_versions();
            results_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got.read_value      = i_res_data[31:0];
                got.created_version = i_res_data[41:32];
                got.status          = i_res_user;
                if (results_due.size() == 0) begin
                    report($sformatf("result value %h version %0d status %0d not expected",
                                     got.read_value, got.created_version, got.status));
                end else begin
                    want = results_due.pop_front();
                    if (got.read_value !== want.read_value)
                        report($sformatf("read_value %h, expected %h",
                                         got.read_value, want.read_value));
                    if (got.created_version !== want.created_version)
                        report($sformatf("created_version %0d, expected %0d",
                                         got.created_version, want.created_version));
                    if (got.status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         got.status, want.status));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                lc = i_cfg_data;
                if (lc < 1) lc = 1;
                if (lc > MAX_LEAVES) lc = MAX_LEAVES;
                leaves = lc;
                drop_versions();
            end
            if (i_req_valid && i_req_ready)
                results_due.push_back(apply_request(i_req_user, i_req_data[9:0],
                                                    i_req_data[20:10], i_req_data[52:21]));
        end
        o_pending <= results_due.size();
    end

endmodule

[tb/persistent_array_path_copy_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top for persistent_array_path_copy_top: directed and random requests
// with bursty sender and stalling receiver; checking is done by the checker module.
// Depends on papc_pkg, persistent_array_path_copy_top, persistent_array_path_copy_checker.
module persistent_array_path_copy_top_tb;
    import papc_pkg::*;

    localparam int MAX_LEAVES    = 1024;
    localparam int POOL_NODES    = 65536;
    localparam int MAX_VERSIONS  = 1024;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 65;
    localparam logic [RT_W-1:0] REQ_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // base_version[9:0], position[20:10], new_value[52:21]
    logic [1:0]  s_axis_tuser;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // read_value[31:0], created_version[41:32]
    logic [2:0]  m_axis_tuser;   // status[2:0]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data;
    int          pending;
    int          fail_count;
    int unsigned cycle_count;

    // stimulus bookkeeping: what the sender believes about the block
    int unsigned leaves_now;
    int unsigned versions_made;
    bit          loaded [0:2047];
    int unsigned loaded_pos [$];
    int unsigned burst_left;

    persistent_array_path_copy_top #(
        .MAX_LEAVES  (MAX_LEAVES),
        .POOL_NODES  (POOL_NODES),
        .MAX_VERSIONS(MAX_VERSIONS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    persistent_array_path_copy_checker #(
        .MAX_LEAVES  (MAX_LEAVES),
        .POOL_NODES  (POOL_NODES),
        .MAX_VERSIONS(MAX_VERSIONS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_user  (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("persistent_array_path_copy_top verification failed");
        $finish;
    end

    // receiver: segments of steady, random or patterned stalls, plus one long hold-off
    initial begin
        int unsigned rx_cycle, seg_left, mode, hold_left;
        m_axis_tready <= 1'b0;
        rx_cycle  = 0;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle == 1500) hold_left = 400;
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 300);
                mode     = $urandom_range(0, 3);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ((rx_cycle % 7) < 4);
                endcase
            end
        end
    end

    // one request transaction, sent in bursts with random gaps
    task automatic send_item(input logic [RT_W-1:0] rt, input logic [BV_W-1:0] bv,
                             input logic [LC_W-1:0] pos, input logic [VAL_W-1:0] val);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rt;
        s_axis_tdata  <= {3'b000, val, pos, bv};
        do @(posedge i_clk); while (!s_axis_tready);
        if (rt == REQ_LOAD && pos >= 1 && pos <= leaves_now && !loaded[pos]) begin
            loaded[pos] = 1'b1;
            loaded_pos.push_back(pos);
        end
        if ((rt == REQ_UPDATE || rt == REQ_QUERY) && bv < versions_made && pos >= 1 &&
            pos <= leaves_now && versions_made < MAX_VERSIONS)
            versions_made++;
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_leaf_count(input logic [LC_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        leaves_now    = (value < 1) ? 1 : (value > MAX_LEAVES) ? MAX_LEAVES : value;
        versions_made = 1;
    endtask

    // mostly the newest versions, sometimes any existing one
    function automatic int unsigned pick_version();
        int unsigned back;
        if ($urandom_range(0, 1)) begin
            back = $urandom_range(0, 3);
            if (back > versions_made - 1) back = versions_made - 1;
            return versions_made - 1 - back;
        end
        return $urandom_range(0, versions_made - 1);
    endfunction

    // a loaded base position inside the current range, or zero if none found
    function automatic int unsigned loaded_in_range();
        int unsigned p;
        if (loaded_pos.size() == 0) return 0;
        for (int i = 0; i < 8; i++) begin
            p = loaded_pos[$urandom_range(0, loaded_pos.size() - 1)];
            if (p <= leaves_now) return p;
        end
        return 0;
    endfunction

    task automatic random_item();
        int unsigned r, pos, bv;
        logic [VAL_W-1:0] val;
        r   = $urandom_range(0, 99);
        val = $urandom;
        if (r < 15) begin
            send_item(REQ_LOAD, $urandom_range(0, 1023), $urandom_range(1, leaves_now), val);
        end else if (r < 50) begin
            pos = $urandom_range(0, 1) ? loaded_in_range() : 0;
            if (pos == 0) pos = $urandom_range(1, leaves_now);
            send_item(REQ_UPDATE, pick_version(), pos, val);
        end else if (r < 90) begin
            // queries only touch loaded base leaves
            pos = loaded_in_range();
            if (pos == 0) send_item(REQ_LOAD, 0, $urandom_range(1, leaves_now), val);
            else send_item(REQ_QUERY, pick_version(), pos, val);
        end else begin
            case ($urandom_range(0, 2))
                0: send_item(REQ_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 2047), val);
                1: begin
                    pos = $urandom_range(0, 1) ? 0 : $urandom_range(leaves_now + 1, 2047);
                    send_item($urandom_range(0, 2), pick_version(), pos, val);
                end
                default: begin
                    if (versions_made < MAX_VERSIONS) begin
                        bv = $urandom_range(versions_made, 1023);
                        send_item($urandom_range(1, 2), bv, $urandom_range(1, leaves_now), val);
                    end else begin
                        send_item(REQ_UNUSED, 0, 0, val);
                    end
                end
            endcase
        end
    endtask

    initial begin
        int unsigned cfg_plan [7];
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        leaves_now    = 1;
        versions_made = 1;
        burst_left    = 0;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single leaf after reset: bad positions, bad version, unknown request
        send_item(REQ_LOAD, 10'd1023, 11'd1, 32'h7FFF_FFFF);
        send_item(REQ_LOAD, 10'd0, 11'd0, 32'h1234_5678);
        send_item(REQ_LOAD, 10'd0, 11'd2, 32'h1234_5678);
        send_item(REQ_QUERY, 10'd0, 11'd1, 32'hFFFF_FFFF);
        send_item(REQ_UPDATE, 10'd1, 11'd1, 32'h8000_0000);
        send_item(REQ_QUERY, 10'd2, 11'd1, 32'h0);
        send_item(REQ_QUERY, 10'd5, 11'd1, 32'h0);
        send_item(REQ_UPDATE, 10'd0, 11'd0, 32'h0);
        send_item(REQ_QUERY, 10'd0, 11'd2047, 32'h0);
        send_item(REQ_UNUSED, 10'd1023, 11'd2047, 32'hFFFF_FFFF);
        send_item(REQ_UPDATE, 10'd0, 11'd1, 32'h0);

        // out-of-range write saturates to the largest tree
        write_leaf_count(11'd2047);
        send_item(REQ_LOAD, 10'd0, 11'd1024, 32'h0000_0001);
        send_item(REQ_LOAD, 10'd0, 11'd1025, 32'h0000_0002);
        send_item(REQ_UPDATE, 10'd0, 11'd1024, 32'hFFFF_FFFF);
        send_item(REQ_QUERY, 10'd1, 11'd1024, 32'h0);
        // late load shows through in versions still sharing the base leaf
        send_item(REQ_LOAD, 10'd0, 11'd1024, 32'h5555_AAAA);
        send_item(REQ_QUERY, 10'd0, 11'd1024, 32'h0);
        send_item(REQ_QUERY, 10'd1, 11'd1024, 32'h0);
        send_item(REQ_QUERY, 10'd1, 11'd1, 32'h0);
        send_item(REQ_UPDATE, 10'd3, 11'd512, 32'd123);
        send_item(REQ_QUERY, 10'd6, 11'd512, 32'h0);

        repeat (200) random_item();

        cfg_plan = '{0, 2, 3, 1023, 1024, $urandom_range(4, 100), $urandom_range(101, 1000)};
        foreach (cfg_plan[i]) begin
            write_leaf_count(cfg_plan[i]);
            repeat (PHASE_ITEMS) random_item();
        end

        // fill the version table on a one-leaf tree, then hit it when full
        write_leaf_count(11'd1);
        send_item(REQ_LOAD, 10'd0, 11'd1, $urandom);
        while (versions_made < MAX_VERSIONS)
            send_item($urandom_range(0, 4) == 0 ? REQ_UPDATE : REQ_QUERY, pick_version(),
                      11'd1, $urandom);
        send_item(REQ_QUERY, 10'd1023, 11'd1, 32'h0);
        send_item(REQ_UPDATE, 10'd0, 11'd1, 32'h0BAD_F00D);
        send_item(REQ_QUERY, 10'd0, 11'd0, 32'h0);
        send_item(REQ_QUERY, 10'd512, 11'd2, 32'h0);
        send_item(REQ_LOAD, 10'd0, 11'd1, $urandom);

        wait_idle();
        if (fail_count == 0) begin
            $display("persistent_array_path_copy_top verification clean");
        end else begin
            $display("persistent_array_path_copy_top verification failed");
        end
        $finish;
    end

endmodule
